// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the slot allocator.
// Depends on nothing; files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/ssa_pkg.sv
// Package of the serial number slot allocator: constants, codes and types.
// Used by the interfaces, the search unit and the top level.
package ssa_pkg;

  localparam int SLOTS       = 256;
  localparam int SLOT_BITS   = 8;
  localparam int HINT_BITS   = 9;
  localparam int HANDLE_BITS = 32;
  localparam int GRP_SIZE    = 16;
  localparam int GRP_BITS    = 4;
  localparam int GRP_COUNT   = SLOTS / GRP_SIZE;

  // Command codes.
  localparam logic [2:0] CMD_ASSIGN   = 3'd0;
  localparam logic [2:0] CMD_UNASSIGN = 3'd1;
  localparam logic [2:0] CMD_GET      = 3'd2;
  localparam logic [2:0] CMD_NEXT     = 3'd3;
  localparam logic [2:0] CMD_PREV     = 3'd4;
  localparam logic [2:0] CMD_FREE     = 3'd5;
  localparam logic [2:0] CMD_CLEAR    = 3'd6;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NONE      = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_TAKEN     = 3'd3;
  localparam logic [2:0] ST_BADHANDLE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_FOUND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]             cmd;
    logic [SLOT_BITS-1:0]   slot_number;
    logic [HANDLE_BITS-1:0] object_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [SLOT_BITS-1:0]   result_number;
    logic [HANDLE_BITS-1:0] result_handle;
    logic [SLOT_BITS-1:0]   entry_count;
    logic [SLOT_BITS-1:0]   highest_number;
  } rsp_t;

  // Result of a bitmap search.
  typedef struct packed {
    logic                 found;
    logic [SLOT_BITS-1:0] idx;
  } hit_t;

endpackage

// File: sv/ssa_req_if.sv
// Request channel of the slot allocator: valid, ready and a request payload.
// Depends on ssa_pkg.
interface ssa_req_if;
  logic          valid;
  logic          ready;
  ssa_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/ssa_rsp_if.sv
// Response channel of the slot allocator: valid, ready and a result payload.
// Depends on ssa_pkg.
interface ssa_rsp_if;
  logic          valid;
  logic          ready;
  ssa_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/ssa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ssa_search.sv
// Two-stage priority search over the occupancy bitmap, lowest or highest bit.
// Depends on ssa_pkg.
module ssa_search (
  input  logic                      clk,
  input  logic [ssa_pkg::SLOTS-1:0] vec,
  input  logic                      high,
  output ssa_pkg::hit_t             hit
);

  logic [ssa_pkg::GRP_COUNT-1:0] grp_any;
  logic [ssa_pkg::GRP_BITS-1:0]  grp_idx [ssa_pkg::GRP_COUNT];
  logic                          high_r;
  logic [ssa_pkg::GRP_COUNT-1:0] any_c;
  logic [ssa_pkg::GRP_BITS-1:0]  idx_c [ssa_pkg::GRP_COUNT];
  ssa_pkg::hit_t                 hit_c;

  // First stage: find the winning bit inside each group.
  always_comb begin
    for (int g = 0; g < ssa_pkg::GRP_COUNT; g++) begin
      any_c[g] = |vec[g*ssa_pkg::GRP_SIZE +: ssa_pkg::GRP_SIZE];
      idx_c[g] = '0;
      for (int j = 0; j < ssa_pkg::GRP_SIZE; j++) begin
        if (high) begin
          if (vec[g*ssa_pkg::GRP_SIZE + j]) begin
            idx_c[g] = ssa_pkg::GRP_BITS'(j);
          end
        end else if (vec[g*ssa_pkg::GRP_SIZE + ssa_pkg::GRP_SIZE - 1 - j]) begin
          idx_c[g] = ssa_pkg::GRP_BITS'(ssa_pkg::GRP_SIZE - 1 - j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= any_c;
    grp_idx <= idx_c;
    high_r  <= high;
  end

  // Second stage: pick the winning group.
  always_comb begin
    hit_c = '0;
    for (int g = 0; g < ssa_pkg::GRP_COUNT; g++) begin
      if (high_r) begin
        if (grp_any[g]) begin
          hit_c.found = 1'b1;
          hit_c.idx   = {ssa_pkg::GRP_BITS'(g), grp_idx[g]};
        end
      end else if (grp_any[ssa_pkg::GRP_COUNT - 1 - g]) begin
        hit_c.found = 1'b1;
        hit_c.idx   = {ssa_pkg::GRP_BITS'(ssa_pkg::GRP_COUNT - 1 - g),
                       grp_idx[ssa_pkg::GRP_COUNT - 1 - g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit_c;
  end

endmodule

// File: sv/serial_number_slot_allocator.sv
// Serial number slot allocator: handles live in a 256 x 32 RAM, occupancy in a bitmap.
// A request steps through the launch, wait, found and done states; one request at a time.
// Each request waits on the two-stage bitmap search and RAM read before it can finish.
// The response register lets a new request be accepted while a response waits.
// Synchronous reset empties the bitmap, sets the free hint to 1, counters to 0.
// Depends on ssa_pkg, ssa_req_if, ssa_rsp_if, ssa_ram, ssa_search, assert_macros.svh.
`include "assert_macros.svh"

module serial_number_slot_allocator (
  input logic        clk,
  input logic        rst,
  ssa_req_if.sink    req,
  ssa_rsp_if.source  rsp
);

  ssa_pkg::state_t                       state, state_next;
  logic [2:0]                            cmd_r;
  logic [ssa_pkg::SLOT_BITS-1:0]         num_r;
  logic [ssa_pkg::HANDLE_BITS-1:0]       hnd_r;
  logic [ssa_pkg::SLOTS-1:0]             occ, occ_next;
  logic [ssa_pkg::HINT_BITS-1:0]         hint, hint_next;
  logic [ssa_pkg::SLOT_BITS-1:0]         highest, highest_next;
  logic [ssa_pkg::SLOT_BITS-1:0]         count, count_next;
  logic                                  out_valid;
  ssa_pkg::rsp_t                         out_r, out_next;
  logic                                  finish;
  logic                                  ram_we;
  logic [ssa_pkg::SLOT_BITS-1:0]         ram_waddr, ram_raddr;
  logic [ssa_pkg::HANDLE_BITS-1:0]       ram_rdata;
  logic [ssa_pkg::SLOTS-1:0]             svec;
  logic                                  shigh;
  ssa_pkg::hit_t                         hit;
  logic [ssa_pkg::HINT_BITS-1:0]         kstart, auto_n;
  logic [ssa_pkg::SLOT_BITS-1:0]         an;

  assign req.ready = (state == ssa_pkg::S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_r;

  // Search vector by command, built from the bitmap, the request number and the free hint.
  assign kstart = (hint == '0) ? ssa_pkg::HINT_BITS'(1) : hint;
  assign shigh  = (cmd_r == ssa_pkg::CMD_PREV) || (cmd_r == ssa_pkg::CMD_UNASSIGN);
  always_comb begin
    for (int i = 0; i < ssa_pkg::SLOTS; i++) begin
      case (cmd_r)
        ssa_pkg::CMD_NEXT:     svec[i] = occ[i] && (ssa_pkg::SLOT_BITS'(i) > num_r);
        ssa_pkg::CMD_PREV:     svec[i] = occ[i] && (ssa_pkg::SLOT_BITS'(i) < num_r);
        ssa_pkg::CMD_FREE:     svec[i] = !occ[i] && (ssa_pkg::HINT_BITS'(i) >= kstart);
        ssa_pkg::CMD_UNASSIGN: svec[i] = occ[i] && (ssa_pkg::SLOT_BITS'(i) != num_r);
        default:               svec[i] = 1'b0;
      endcase
    end
  end

  ssa_search u_search (
    .clk  (clk),
    .vec  (svec),
    .high (shigh),
    .hit  (hit)
  );

  // The handle table.
  assign ram_raddr = ((cmd_r == ssa_pkg::CMD_NEXT) || (cmd_r == ssa_pkg::CMD_PREV)) ?
                     hit.idx : num_r;
  ssa_ram #(
    .WIDTH (ssa_pkg::HANDLE_BITS),
    .DEPTH (ssa_pkg::SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (hnd_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Number for an assign: given, or highest plus one.
  assign auto_n    = (num_r == '0) ? ({1'b0, highest} + ssa_pkg::HINT_BITS'(1)) :
                     {1'b0, num_r};
  assign an        = auto_n[ssa_pkg::SLOT_BITS-1:0];
  assign ram_waddr = an;

  // Next state, and the results and state updates of a finished request.
  always_comb begin
    state_next   = state;
    finish       = 1'b0;
    ram_we       = 1'b0;
    occ_next     = occ;
    hint_next    = hint;
    highest_next = highest;
    count_next   = count;
    out_next     = '0;
    out_next.status = ssa_pkg::ST_RANGE;
    case (state)
      ssa_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = ssa_pkg::S_LAUNCH;
        end
      end
      ssa_pkg::S_LAUNCH: state_next = ssa_pkg::S_WAIT;
      ssa_pkg::S_WAIT:   state_next = ssa_pkg::S_FOUND;
      ssa_pkg::S_FOUND:  state_next = ssa_pkg::S_DONE;
      ssa_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          finish     = 1'b1;
          state_next = ssa_pkg::S_IDLE;
          case (cmd_r)
            ssa_pkg::CMD_ASSIGN: begin
              if (hnd_r == '0) begin
                out_next.status = ssa_pkg::ST_BADHANDLE;
              end else if (auto_n[ssa_pkg::SLOT_BITS]) begin
                out_next.status = ssa_pkg::ST_RANGE;
              end else if (occ[an]) begin
                out_next.status = ssa_pkg::ST_TAKEN;
              end else begin
                ram_we       = 1'b1;
                occ_next[an] = 1'b1;
                count_next   = count + 1'b1;
                if (an > highest) begin
                  highest_next = an;
                end
                out_next.status        = ssa_pkg::ST_OK;
                out_next.result_number = an;
                out_next.result_handle = hnd_r;
              end
            end
            ssa_pkg::CMD_UNASSIGN: begin
              if (num_r == '0) begin
                out_next.status = ssa_pkg::ST_RANGE;
              end else if (!occ[num_r]) begin
                out_next.status = ssa_pkg::ST_NONE;
              end else begin
                occ_next[num_r] = 1'b0;
                count_next      = count - 1'b1;
                if (hint > {1'b0, num_r}) begin
                  hint_next = {1'b0, num_r};
                end
                highest_next           = hit.found ? hit.idx : '0;
                out_next.status        = ssa_pkg::ST_OK;
                out_next.result_number = num_r;
                out_next.result_handle = ram_rdata;
              end
            end
            ssa_pkg::CMD_GET: begin
              out_next.status        = occ[num_r] ? ssa_pkg::ST_OK : ssa_pkg::ST_NONE;
              out_next.result_number = num_r;
              out_next.result_handle = occ[num_r] ? ram_rdata : '0;
            end
            ssa_pkg::CMD_NEXT, ssa_pkg::CMD_PREV: begin
              if (hit.found) begin
                out_next.status        = ssa_pkg::ST_OK;
                out_next.result_number = hit.idx;
                out_next.result_handle = ram_rdata;
              end else begin
                out_next.status = ssa_pkg::ST_NONE;
              end
            end
            ssa_pkg::CMD_FREE: begin
              if (hit.found) begin
                hint_next              = {1'b0, hit.idx};
                out_next.status        = ssa_pkg::ST_OK;
                out_next.result_number = hit.idx;
              end else begin
                hint_next       = ssa_pkg::HINT_BITS'(ssa_pkg::SLOTS);
                out_next.status = ssa_pkg::ST_RANGE;
              end
            end
            ssa_pkg::CMD_CLEAR: begin
              occ_next        = '0;
              hint_next       = ssa_pkg::HINT_BITS'(1);
              highest_next    = '0;
              count_next      = '0;
              out_next.status = ssa_pkg::ST_OK;
            end
            default: out_next.status = ssa_pkg::ST_RANGE;
          endcase
          out_next.entry_count    = count_next;
          out_next.highest_number = highest_next;
        end
      end
      default: state_next = ssa_pkg::S_IDLE;
    endcase
  end

  // Control and table state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssa_pkg::S_IDLE;
      occ       <= '0;
      hint      <= ssa_pkg::HINT_BITS'(1);
      highest   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      occ     <= occ_next;
      hint    <= hint_next;
      highest <= highest_next;
      count   <= count_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and response register.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_r <= req.data.cmd;
      num_r <= req.data.slot_number;
      hnd_r <= req.data.object_handle;
    end
    if (finish) begin
      out_r <= out_next;
    end
  end

  `CHK_ASSERT(a_slot0_free, clk, rst, !occ[0], "slot 0 became occupied")
  `CHK_ASSERT(a_empty_top, clk, rst, (count == '0) |-> (highest == '0), "empty table has a top")
  `CHK_ASSERT(a_top_used, clk, rst, (highest != '0) |-> occ[highest], "highest slot is empty")
  `CHK_ASSERT(a_done_hold, clk, rst, (state == ssa_pkg::S_DONE) && out_valid && !rsp.ready |=> (state == ssa_pkg::S_DONE), "result overwrote a pending response")

endmodule
